// ----- hdl/nvt_pkg.sv -----
`timescale 1ns / 1ps

package nvt_pkg;

    localparam int PROB_W  = 9;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int WIDTH_W = 11;
    localparam int SCORE_W = 14;

    // register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd480;

    localparam logic [SCORE_W-1:0] CENTRE_WEIGHT = 14'd10;
    // 0.6 * 256 * 10
    localparam logic [SCORE_W-1:0] THRESHOLD     = 14'd1536;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              start_of_frame;
    } t_pix_beat;

    typedef struct packed {
        logic [ROW_W-1:0] pixel_row;
        logic [COL_W-1:0] pixel_column;
        logic             is_foreground;
        logic             last_of_frame;
    } t_res_beat;

endpackage

// ----- hdl/nvt_in_if.sv -----
`timescale 1ns / 1ps

interface nvt_in_if;
    logic                  valid;
    logic                  ready;
    nvt_pkg::t_pix_beat    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/nvt_out_if.sv -----
`timescale 1ns / 1ps

interface nvt_out_if;
    logic                  valid;
    logic                  ready;
    nvt_pkg::t_res_beat    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/nvt_ram.sv -----
`timescale 1ns / 1ps

module nvt_ram #(
    parameter int WIDTH  = 9,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read-first: a read at the written address returns the old word
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/neighborhood_vote_threshold_3x3.sv -----
// 3x3 neighborhood vote over a raster stream of background probabilities.
// i_pix (sink) takes one pixel per beat: a 9-bit probability (256 = 1.0)
// and a start_of_frame flag that puts the pixel at row 0, column 0.
// o_res (source) gives one beat per interior pixel: its row and column,
// is_foreground (1 when 10*centre + sum of neighbors <= 1536) and
// last_of_frame on the final interior pixel. Border pixels give no beat.
// Image width and height are set over the APB port (width at 0x0, height at
// 0x4); the user must write them only while the stream is idle, which the
// block does not enforce. Widths outside 3..MAX_WIDTH and heights below 3
// are clamped. One pixel per clock is sustained while o_res takes results.
// The two line buffers are single memories read at accept and written back
// when the read stage advances; a back-to-back access to the same column is
// forwarded. A result is valid on o_res once it leaves the read stage.
// When o_res stalls, the result waits in the output register and pixels
// that decide nothing still pass; the next pixel that completes a window
// is held in the read stage and i_pix.ready drops until the result is taken.
// Reset (i_rst_n low, synchronous) clears position, window and handshakes
// and loads width 640, height 480. Line buffers are not cleared, so there
// is no clearing pass; the first two rows of a frame fill them.
`timescale 1ns / 1ps

module neighborhood_vote_threshold_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nvt_in_if.sink            i_pix,
    nvt_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PROB_W  = nvt_pkg::PROB_W;
    localparam int ROW_W   = nvt_pkg::ROW_W;
    localparam int COL_W   = nvt_pkg::COL_W;
    localparam int WIDTH_W = nvt_pkg::WIDTH_W;
    localparam int SCORE_W = nvt_pkg::SCORE_W;
    localparam int SLOT_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SIZE_W  = 13;

    localparam logic [SIZE_W-1:0] MAX_W_SZ  = SIZE_W'(MAX_WIDTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WIDTH - 1);

    // configuration
    logic [WIDTH_W-1:0] r_cfg_width;
    logic [ROW_W-1:0]   r_cfg_height;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= nvt_pkg::WIDTH_RESET;
            r_cfg_height <= nvt_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                nvt_pkg::REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[WIDTH_W-1:0];
                nvt_pkg::REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            nvt_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_cfg_width);
            nvt_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_cfg_height);
            default:                   prdata = '0;
        endcase
    end

    // effective sizes
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    always_comb begin
        if (r_cfg_width < WIDTH_W'(3)) begin
            w_eff = SIZE_W'(3);
        end else if (SIZE_W'(r_cfg_width) > MAX_W_SZ) begin
            w_eff = MAX_W_SZ;
        end else begin
            w_eff = SIZE_W'(r_cfg_width);
        end
        if (r_cfg_height < ROW_W'(3)) begin
            h_eff = SIZE_W'(3);
        end else begin
            h_eff = SIZE_W'(r_cfg_height);
        end
    end

    // stage 0: position and line-buffer read
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [SLOT_W-1:0] n_slot;

    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_emit;
    logic              cur_last;
    logic              in_acc;

    // stage 1 registers
    logic              r_s1_valid;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [PROB_W-1:0] r_s1_p;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_fwd;
    logic [PROB_W-1:0] r_fwd_top;
    logic [PROB_W-1:0] r_fwd_mid;
    logic              s1_adv;

    logic              r_out_valid;
    nvt_pkg::t_res_beat r_out;

    assign s1_adv      = r_s1_valid && (!r_s1_emit || !r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_comb begin
        if (i_pix.data.start_of_frame) begin
            cur_row  = '0;
            cur_col  = '0;
            cur_slot = '0;
        end else begin
            cur_row  = r_row;
            cur_col  = r_col;
            cur_slot = r_slot;
        end
        cur_emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2))
                && (SIZE_W'(cur_row) < h_eff) && (SIZE_W'(cur_col) < w_eff);
        cur_last = (SIZE_W'(cur_row) == h_eff - SIZE_W'(1))
                && (SIZE_W'(cur_col) == w_eff - SIZE_W'(1));

        if (SIZE_W'(cur_col) + SIZE_W'(1) >= w_eff) begin
            n_col  = '0;
            n_slot = '0;
            if (SIZE_W'(cur_row) + SIZE_W'(1) >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = cur_row + ROW_W'(1);
            end
        end else begin
            n_col  = cur_col + COL_W'(1);
            n_row  = cur_row;
            n_slot = (cur_slot == SLOT_LAST) ? '0 : cur_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (in_acc) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    // stage 1: read data back, window, write back
    logic [PROB_W-1:0] ram_top;
    logic [PROB_W-1:0] ram_mid;
    logic [PROB_W-1:0] s1_top;
    logic [PROB_W-1:0] s1_mid;
    logic [PROB_W-1:0] r_win [6];
    logic [SCORE_W-1:0] score;

    assign s1_top = r_s1_fwd ? r_fwd_top : ram_top;
    assign s1_mid = r_s1_fwd ? r_fwd_mid : ram_mid;

    nvt_ram #(
        .WIDTH (PROB_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_slot),
        .i_wdata (s1_mid),
        .i_re    (in_acc),
        .i_raddr (cur_slot),
        .o_rdata (ram_top)
    );

    nvt_ram #(
        .WIDTH (PROB_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_slot),
        .i_wdata (r_s1_p),
        .i_re    (in_acc),
        .i_raddr (cur_slot),
        .o_rdata (ram_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            // the write-back at this edge hits the column just read
            r_s1_fwd   <= s1_adv && (r_s1_slot == cur_slot);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_slot <= cur_slot;
            r_s1_p    <= i_pix.data.probability;
            r_s1_emit <= cur_emit;
            r_s1_last <= cur_last;
            r_s1_row  <= cur_row - ROW_W'(1);
            r_s1_col  <= cur_col - COL_W'(1);
            r_fwd_top <= s1_mid;
            r_fwd_mid <= r_s1_p;
        end
    end

    // window columns: 0..2 = column c-2, 3..5 = column c-1 (top, mid, bottom)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_p;
        end
    end

    always_comb begin
        score = SCORE_W'(r_win[0]) + SCORE_W'(r_win[1]) + SCORE_W'(r_win[2])
              + SCORE_W'(r_win[3]) + SCORE_W'(r_win[5])
              + SCORE_W'(s1_top) + SCORE_W'(s1_mid) + SCORE_W'(r_s1_p)
              + SCORE_W'(r_win[4]) * nvt_pkg::CENTRE_WEIGHT;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out.pixel_row     <= r_s1_row;
            r_out.pixel_column  <= r_s1_col;
            r_out.is_foreground <= (score <= nvt_pkg::THRESHOLD);
            r_out.last_of_frame <= r_s1_last;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_s1_valid || s1_adv))
        else $error("pixel taken while read stage is blocked");

    a_fwd_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("forward flag set with empty read stage");

    a_fwd_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s1_adv && (r_s1_slot == cur_slot)) |=> r_s1_fwd)
        else $error("same-column access not forwarded");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("line buffer slot out of range");

    a_no_border_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.pixel_column != '0 && r_out.pixel_row != '0))
        else $error("result for a border pixel");
`endif

endmodule
